// ----- rtl/rgb_to_hsv_defines.svh -----
// Assertion macros shared by the rgb_to_hsv RTL files.
`ifndef RGB_TO_HSV_DEFINES_SVH
`define RGB_TO_HSV_DEFINES_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define RTH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rgb_to_hsv check failed");
// A condition in one cycle that requires another in the next cycle.
`define RTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rgb_to_hsv check failed");
`else
`define RTH_ASSERT(lbl, clk, rstn, prop)
`define RTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/rth_pkg.sv -----
// Types and constants shared by the rgb_to_hsv pipeline.
`default_nettype none
package rth_pkg;

    localparam int CH_W      = 8;   // width of one colour channel
    localparam int Q_W       = 16;  // width of the hue and saturation fractions
    localparam int HUE_W     = 11;  // holds six times the largest delta
    localparam int DIV_STEPS = Q_W; // one quotient bit per divider stage
    localparam int S_TDATA_W = 3 * CH_W;
    localparam int M_TDATA_W = 2 * Q_W + CH_W;

    // Working state of both long divisions as it travels down the pipe.
    typedef struct packed {
        logic [HUE_W-1:0] hue_rem;
        logic [HUE_W-1:0] hue_div;
        logic [Q_W-1:0]   hue_quo;
        logic [CH_W-1:0]  sat_rem;
        logic [CH_W-1:0]  sat_div;  // also the brightness of the pixel
        logic [Q_W-1:0]   sat_low;
        logic [Q_W-1:0]   sat_quo;
        logic             hue_zero;
        logic             sat_zero;
    } rth_div_t;

endpackage
`default_nettype wire

// ----- rtl/rth_div_stage.sv -----
// One registered step of the hue and saturation restoring dividers.
`default_nettype none
`include "rgb_to_hsv_defines.svh"
module rth_div_stage import rth_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire rth_div_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output rth_div_t      out_data
);

    logic             valid_reg;
    logic             valid_next;
    rth_div_t         data_reg;
    rth_div_t         data_next;
    logic [HUE_W:0]   hue_trial;
    logic             hue_ge;
    logic [CH_W:0]    sat_trial;
    logic             sat_ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        hue_trial = {in_data.hue_rem, 1'b0};
        hue_ge    = hue_trial >= {1'b0, in_data.hue_div};
        sat_trial = {in_data.sat_rem, in_data.sat_low[Q_W-1]};
        sat_ge    = sat_trial >= {1'b0, in_data.sat_div};

        data_next         = in_data;
        data_next.hue_rem = hue_ge ? HUE_W'(hue_trial - {1'b0, in_data.hue_div})
                                   : hue_trial[HUE_W-1:0];
        data_next.hue_quo = {in_data.hue_quo[Q_W-2:0], hue_ge};
        data_next.sat_rem = sat_ge ? CH_W'(sat_trial - {1'b0, in_data.sat_div})
                                   : sat_trial[CH_W-1:0];
        data_next.sat_low = {in_data.sat_low[Q_W-2:0], 1'b0};
        data_next.sat_quo = {in_data.sat_quo[Q_W-2:0], sat_ge};

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    // The partial remainders stay below their divisors after every step.
    `RTH_ASSERT(a_hue_rem_bound, aclk, aresetn, (valid_reg && !data_reg.hue_zero) |-> (data_reg.hue_rem < data_reg.hue_div))
    `RTH_ASSERT(a_sat_rem_bound, aclk, aresetn, (valid_reg && !data_reg.sat_zero) |-> (data_reg.sat_rem < data_reg.sat_div))

endmodule
`default_nettype wire

// ----- rtl/rgb_to_hsv.sv -----
// Top level of the pipelined RGB to HSV converter.
// Each item passes three front stages, sixteen divider stages and the output register.
// Throughput: one item per clock without back-pressure; each of these stages takes one
// item a cycle, so the rate is set by the single-bit divider step.
// Back-pressure stalls only the stages that hold data, so bubbles close up.
// Reset: synchronous, active low on aresetn; it empties every stage of the pipe.
`default_nettype none
`include "rgb_to_hsv_defines.svh"
module rgb_to_hsv import rth_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // red [7:0], green [15:8], blue [23:16]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata   // hue [15:0], saturation [31:16],
                                                // brightness [39:32]
);

    // The channel that holds the maximum; red wins ties, then green.
    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } sector_t;

    // Stage one: maximum, minimum and the sector of the maximum.
    logic            f1_valid_reg;
    logic            f1_valid_next;
    logic            f1_ready;
    logic [CH_W-1:0] f1_red_reg,   f1_red_next;
    logic [CH_W-1:0] f1_green_reg, f1_green_next;
    logic [CH_W-1:0] f1_blue_reg,  f1_blue_next;
    logic [CH_W-1:0] f1_max_reg,   f1_max_next;
    logic [CH_W-1:0] f1_min_reg,   f1_min_next;
    sector_t         f1_sector_reg, f1_sector_next;
    logic [CH_W-1:0] rg_max;
    logic [CH_W-1:0] rg_min;

    // Stage two: delta, six times delta and the signed channel difference.
    logic             f2_valid_reg;
    logic             f2_valid_next;
    logic             f2_ready;
    logic [CH_W-1:0]  f2_max_reg,   f2_max_next;
    logic [CH_W-1:0]  f2_delta_reg, f2_delta_next;
    logic [HUE_W-1:0] f2_six_reg,   f2_six_next;
    logic [CH_W:0]    f2_diff_reg,  f2_diff_next;
    logic             f2_wrap_reg,  f2_wrap_next;
    sector_t          f2_sector_reg;

    // Stage three: hue numerator and the starting state of both dividers.
    logic             f3_valid_reg;
    logic             f3_valid_next;
    logic             f3_ready;
    rth_div_t         f3_data_reg;
    rth_div_t         f3_data_next;
    logic [HUE_W:0]   hue_base;
    logic [HUE_W:0]   hue_num;
    logic [3*CH_W-1:0] sat_dividend;

    // Divider chain; element zero is the output of stage three.
    logic     chain_valid [0:DIV_STEPS];
    logic     chain_ready [0:DIV_STEPS];
    rth_div_t chain_data  [0:DIV_STEPS];

    // Output register.
    logic            out_valid_reg, out_valid_next;
    logic            out_ready;
    logic [Q_W-1:0]  out_hue_reg,    out_hue_next;
    logic [Q_W-1:0]  out_sat_reg,    out_sat_next;
    logic [CH_W-1:0] out_bright_reg, out_bright_next;

    // ------------------------------------------------------------------
    // Stage one. A stage takes a new item whenever it is empty or its own
    // item moves on in the same cycle.
    // ------------------------------------------------------------------
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign s_tready = f1_ready;

    always_comb begin
        f1_red_next   = s_tdata[CH_W-1:0];
        f1_green_next = s_tdata[2*CH_W-1:CH_W];
        f1_blue_next  = s_tdata[3*CH_W-1:2*CH_W];
        rg_max        = (f1_red_next >= f1_green_next) ? f1_red_next : f1_green_next;
        rg_min        = (f1_red_next <= f1_green_next) ? f1_red_next : f1_green_next;
        f1_max_next   = (rg_max >= f1_blue_next) ? rg_max : f1_blue_next;
        f1_min_next   = (rg_min <= f1_blue_next) ? rg_min : f1_blue_next;
        if (f1_red_next == f1_max_next) begin
            f1_sector_next = SEC_RED;
        end else if (f1_green_next == f1_max_next) begin
            f1_sector_next = SEC_GREEN;
        end else begin
            f1_sector_next = SEC_BLUE;
        end
        f1_valid_next = f1_ready ? s_tvalid : f1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && f1_ready) begin
            f1_red_reg    <= f1_red_next;
            f1_green_reg  <= f1_green_next;
            f1_blue_reg   <= f1_blue_next;
            f1_max_reg    <= f1_max_next;
            f1_min_reg    <= f1_min_next;
            f1_sector_reg <= f1_sector_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage two. The hue numerator is k*delta plus a channel difference;
    // here the difference is formed for the sector, and a red maximum with
    // green below blue is flagged so that six deltas are added later.
    // ------------------------------------------------------------------
    assign f2_ready = !f2_valid_reg || f3_ready;

    always_comb begin
        f2_max_next   = f1_max_reg;
        f2_delta_next = f1_max_reg - f1_min_reg;
        f2_six_next   = HUE_W'({3'b000, f2_delta_next} << 2)
                      + HUE_W'({3'b000, f2_delta_next} << 1);
        f2_wrap_next  = 1'b0;
        case (f1_sector_reg)
            SEC_RED: begin
                f2_diff_next = {1'b0, f1_green_reg} - {1'b0, f1_blue_reg};
                f2_wrap_next = f1_green_reg < f1_blue_reg;
            end
            SEC_GREEN: begin
                f2_diff_next = {1'b0, f1_blue_reg} - {1'b0, f1_red_reg};
            end
            SEC_BLUE: begin
                f2_diff_next = {1'b0, f1_red_reg} - {1'b0, f1_green_reg};
            end
            default: begin
                f2_diff_next = '0;
            end
        endcase
        f2_valid_next = f2_ready ? f1_valid_reg : f2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (f1_valid_reg && f2_ready) begin
            f2_max_reg    <= f2_max_next;
            f2_delta_reg  <= f2_delta_next;
            f2_six_reg    <= f2_six_next;
            f2_diff_reg   <= f2_diff_next;
            f2_wrap_reg   <= f2_wrap_next;
            f2_sector_reg <= f1_sector_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage three. The hue numerator never exceeds six deltas; when it
    // equals them the hue is one whole turn, which wraps to zero, so the
    // integer quotient bit is dropped by starting from a zero remainder.
    // The saturation dividend is delta*65535, formed as delta*65536 - delta;
    // its top byte is already below the maximum, so only sixteen quotient
    // bits remain to be found.
    // ------------------------------------------------------------------
    assign f3_ready = !f3_valid_reg || chain_ready[0];

    always_comb begin
        case (f2_sector_reg)
            SEC_RED:   hue_base = f2_wrap_reg ? {1'b0, f2_six_reg} : '0;
            SEC_GREEN: hue_base = {3'b000, f2_delta_reg, 1'b0};
            SEC_BLUE:  hue_base = {2'b00, f2_delta_reg, 2'b00};
            default:   hue_base = '0;
        endcase
        hue_num      = hue_base + {{(HUE_W-CH_W){f2_diff_reg[CH_W]}}, f2_diff_reg};
        sat_dividend = {f2_delta_reg, {Q_W{1'b0}}} - {{Q_W{1'b0}}, f2_delta_reg};

        f3_data_next.hue_div  = f2_six_reg;
        f3_data_next.hue_rem  = (hue_num[HUE_W-1:0] == f2_six_reg) ? '0
                                                                   : hue_num[HUE_W-1:0];
        f3_data_next.hue_quo  = '0;
        f3_data_next.sat_div  = f2_max_reg;
        f3_data_next.sat_rem  = sat_dividend[3*CH_W-1:Q_W];
        f3_data_next.sat_low  = sat_dividend[Q_W-1:0];
        f3_data_next.sat_quo  = '0;
        f3_data_next.hue_zero = f2_delta_reg == '0;
        f3_data_next.sat_zero = f2_max_reg == '0;

        f3_valid_next = f3_ready ? f2_valid_reg : f3_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (f2_valid_reg && f3_ready) begin
            f3_data_reg <= f3_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Sixteen divider stages, each finding one bit of both quotients.
    // ------------------------------------------------------------------
    assign chain_valid[0] = f3_valid_reg;
    assign chain_data[0]  = f3_data_reg;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        rth_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register. A grey pixel has no hue and a black pixel has no
    // saturation; both are forced to zero here.
    // ------------------------------------------------------------------
    assign out_ready                = !out_valid_reg || m_tready;
    assign chain_ready[DIV_STEPS]   = out_ready;

    always_comb begin
        out_hue_next    = chain_data[DIV_STEPS].hue_zero ? '0 : chain_data[DIV_STEPS].hue_quo;
        out_sat_next    = chain_data[DIV_STEPS].sat_zero ? '0 : chain_data[DIV_STEPS].sat_quo;
        out_bright_next = chain_data[DIV_STEPS].sat_div;
        out_valid_next  = out_ready ? chain_valid[DIV_STEPS] : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (chain_valid[DIV_STEPS] && out_ready) begin
            out_hue_reg    <= out_hue_next;
            out_sat_reg    <= out_sat_next;
            out_bright_reg <= out_bright_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg  <= f1_valid_next;
            f2_valid_reg  <= f2_valid_next;
            f3_valid_reg  <= f3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bright_reg, out_sat_reg, out_hue_reg};

    // A black pixel leaves with zero hue and zero saturation.
    `RTH_ASSERT(a_black_pixel, aclk, aresetn, (out_valid_reg && out_bright_reg == '0) |-> (out_sat_reg == '0 && out_hue_reg == '0))
    // A new result only appears when the last divider stage held an item.
    `RTH_ASSERT(a_out_from_chain, aclk, aresetn, $rose(out_valid_reg) |-> $past(chain_valid[DIV_STEPS]))
    // The input side only stalls when the front stages and the output are all full.
    `RTH_ASSERT(a_full_when_stalled, aclk, aresetn, !s_tready |-> (f1_valid_reg && f2_valid_reg && f3_valid_reg && out_valid_reg))

endmodule
`default_nettype wire
